[sv/fse2d_pkg.sv]
// ----------------------------------------------------------------------------
// fse2d_pkg
// Shared types and constants for the 2-D Fourier series evaluator.
// ----------------------------------------------------------------------------
package fse2d_pkg;

   localparam int COEFF_W = 18;
   localparam int ENTRY_W = 2 * COEFF_W;
   localparam int INDEX_W = 7;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // 1/(2*pi) in Q0.28
   localparam logic signed [27:0] INV_TWO_PI = 28'sd42722830;

   // polynomial coefficients, Q.24
   localparam logic signed [31:0] COS_C0 = 32'sd16777216;
   localparam logic signed [31:0] COS_C2 = -32'sd331168970;
   localparam logic signed [31:0] COS_C4 = 32'sd1089502240;
   localparam logic signed [31:0] COS_C6 = -32'sd1433727481;
   localparam logic signed [31:0] SIN_S1 = 32'sd105414357;
   localparam logic signed [31:0] SIN_S3 = -32'sd693598668;
   localparam logic signed [31:0] SIN_S5 = 32'sd1369108894;
   localparam logic signed [31:0] SIN_S7 = -32'sd1286910781;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // control from sequencer to the term datapath
   typedef struct packed {
      logic       start;   // clear sum
      logic       valid;   // term is present on the memory read port
      logic signed [4:0] n;
      logic signed [4:0] m;
   } term_ctl_type;

endpackage

[sv/fourier_series_2d_evaluator.sv]
// ----------------------------------------------------------------------------
// fourier_series_2d_evaluator
// Loads a complex coefficient table and evaluates a 2-D Fourier series.
// ----------------------------------------------------------------------------
// Input channel req_*: cmd LOAD writes one table entry and returns no word;
// an index beyond the table is dropped. cmd EVAL returns one rsp_ word with
// the series value (Q16.16, saturated) and empty_table.
// Throughput: one load per cycle while idle. An evaluate reads entry 0,
// then walks all (2K+1)^2 entries through the table RAM read port, one term
// per cycle into an 11-stage term pipeline. If entry 0 reads as zero, the
// table counts as empty and the answer is zero with empty_table set.
// After reset the block runs a clearing pass over every table RAM entry
// and accepts no word meanwhile.
// The result sits in an output register; while rsp_stall is high it holds
// and the block still takes loads, but no new evaluate.
// ----------------------------------------------------------------------------
module fourier_series_2d_evaluator #(
   parameter int HARMONIC_ORDER = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_cmd,
   input  logic [6:0]   req_coeff_index,
   input  logic signed [17:0] req_coeff_real,
   input  logic signed [17:0] req_coeff_imag,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic signed [31:0] rsp_series_value,
   output logic         rsp_empty_table
);
   import fse2d_pkg::*;

   localparam int DIM  = 2 * HARMONIC_ORDER + 1;
   localparam int SIZE = DIM * DIM;
   localparam int AW   = $clog2(SIZE);

   state_type state_ff, state_in;
   logic [AW:0]   clr_ff, clr_in;
   logic          clr_busy;
   logic [AW-1:0] addr_ff, addr_in;
   logic signed [4:0] n_ff, n_in, m_ff, m_in;
   logic          rd_vld_ff, rd_vld_in;
   logic signed [31:0] x_ff, y_ff;
   logic          out_vld_ff, out_vld_in;
   logic signed [31:0] out_val_ff, out_val_in;
   logic          out_emp_ff, out_emp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic          acc;
   term_ctl_type  ctl;
   logic          t_busy;
   logic signed [63:0] t_sum;
   logic signed [63:0] rsum;
   logic signed [17:0] c_re, c_im, c_re_g, c_im_g;

   assign clr_busy = (clr_ff != (AW+1)'(SIZE));
   assign req_stall = clr_busy || (state_ff != ST_IDLE) ||
                      (req_cmd == CMD_EVAL && out_vld_ff);
   assign acc = req_valid && !req_stall;

   always_comb begin
      if (clr_busy) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff[AW-1:0];
         wr_data = '0;
      end else begin
         wr_en   = acc && req_cmd == CMD_LOAD &&
                   {1'b0, req_coeff_index} < 8'(SIZE);
         wr_addr = AW'(req_coeff_index);
         wr_data = {req_coeff_real, req_coeff_imag};
      end
      rd_addr = addr_ff;
   end

   fse2d_ram #(.WIDTH(ENTRY_W), .DEPTH(SIZE)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign c_re = $signed(rd_data[ENTRY_W-1:COEFF_W]);
   assign c_im = $signed(rd_data[COEFF_W-1:0]);
   assign c_re_g = rd_vld_ff ? c_re : '0;
   assign c_im_g = rd_vld_ff ? c_im : '0;

   // term for the entry read last cycle
   logic signed [4:0] tn_ff, tm_ff;
   assign ctl.start = acc && req_cmd == CMD_EVAL;
   assign ctl.valid = rd_vld_ff;
   assign ctl.n = tn_ff;
   assign ctl.m = tm_ff;

   fse2d_term u_term (
      .clock(clock), .reset(reset), .ctl(ctl),
      .x_val(x_ff), .y_val(y_ff), .c_re(c_re_g), .c_im(c_im_g),
      .busy(t_busy), .sum(t_sum)
   );

   assign rsum = (t_sum + 64'sd8388608) >>> 24;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_busy ? clr_ff + 1'b1 : clr_ff;
      addr_in    = addr_ff;
      n_in       = n_ff;
      m_in       = m_ff;
      rd_vld_in  = 1'b0;
      out_vld_in = out_vld_ff && rsp_stall;
      out_val_in = out_val_ff;
      out_emp_in = out_emp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               addr_in  = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // entry 0 read data valid next cycle; wait here and set the indices
            n_in     = -5'(HARMONIC_ORDER);
            m_in     = -5'(HARMONIC_ORDER);
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (addr_ff == '0 && !rd_vld_ff && rd_data == '0) begin
               out_vld_in = 1'b1;
               out_val_in = '0;
               out_emp_in = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               rd_vld_in = 1'b1;
               if (addr_ff == AW'(SIZE - 1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
               if (m_ff == 5'(HARMONIC_ORDER)) begin
                  m_in = -5'(HARMONIC_ORDER);
                  n_in = n_ff + 1'b1;
               end else begin
                  m_in = m_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !t_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            out_vld_in = 1'b1;
            out_emp_in = 1'b0;
            if (rsum > 64'sd2147483647) begin
               out_val_in = 32'sh7FFF_FFFF;
            end else if (rsum < -64'sd2147483648) begin
               out_val_in = 32'sh8000_0000;
            end else begin
               out_val_in = rsum[31:0];
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         clr_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      n_ff       <= n_in;
      m_ff       <= m_in;
      tn_ff      <= n_ff;
      tm_ff      <= m_ff;
      out_val_ff <= out_val_in;
      out_emp_ff <= out_emp_in;
      if (ctl.start) begin
         x_ff <= req_x_coord;
         y_ff <= req_y_coord;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_series_value = out_val_ff;
   assign rsp_empty_table  = out_emp_ff;

   a_no_acc_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !acc) else $error("word accepted during table clear");
   a_walk_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_table) |-> rsp_series_value == '0)
      else $error("empty result not zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_series_value))
      else $error("result dropped under stall");

endmodule

[sv/fse2d_ram.sv]
// ----------------------------------------------------------------------------
// fse2d_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module fse2d_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 81
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[sv/fse2d_term.sv]
// ----------------------------------------------------------------------------
// fse2d_term
// Pipelined term unit: phase, range reduction, sin/cos polynomials, accumulate.
// ----------------------------------------------------------------------------
module fse2d_term (
   input  logic                        clock,
   input  logic                        reset,
   input  fse2d_pkg::term_ctl_type     ctl,
   input  logic signed [31:0]          x_val,
   input  logic signed [31:0]          y_val,
   input  logic signed [17:0]          c_re,
   input  logic signed [17:0]          c_im,
   output logic                        busy,
   output logic signed [63:0]          sum
);
   import fse2d_pkg::*;

   localparam int NSTG = 11;

   // stage valid shift line
   logic [NSTG-1:0] vld_ff, vld_in;

   // stage 1: phase products
   logic signed [36:0] px_ff, py_ff;
   logic signed [17:0] re1_ff, im1_ff;
   // stage 2: phase sum
   logic signed [37:0] ph_ff;
   logic signed [17:0] re2_ff, im2_ff;
   // stage 3: turns (multiply split: low 19 bits / high 19 bits of phase)
   logic signed [47:0] tl_ff;
   logic signed [47:0] th_ff;
   logic signed [17:0] re3_ff, im3_ff;
   // stage 4: combine, fraction
   logic signed [32:0] f_ff;
   logic signed [17:0] re4_ff, im4_ff;
   // stage 5: f*f
   logic [63:0]        ff_ff;
   logic signed [32:0] f5_ff;
   logic signed [17:0] re5_ff, im5_ff;
   // stages 6..11 polynomial; x2 carried
   logic signed [31:0] x2_ff [6:8];
   logic signed [32:0] fp_ff [6:9];
   logic signed [17:0] rep_ff [6:11];
   logic signed [17:0] imp_ff [6:11];
   logic signed [31:0] c_ff [6:11];
   logic signed [31:0] s_ff [6:11];
   logic signed [63:0] sum_ff;

   function automatic logic signed [31:0] rnd(input logic signed [63:0] p,
                                             input int sh);
      logic signed [63:0] t;
      begin
         t = (p + (64'sd1 <<< (sh - 1))) >>> sh;
         return t[31:0];
      end
   endfunction

   logic [31:0] lo_w;
   logic        odd_w;
   logic signed [63:0] turns_w;
   logic signed [32:0] f_w;
   logic signed [31:0] x2_w;

   always_comb begin
      turns_w = 64'((tl_ff >>> 12) + (th_ff <<< 7));
      lo_w    = turns_w[31:0];
      odd_w   = turns_w[32];
      if (lo_w > 32'h8000_0000 || (lo_w == 32'h8000_0000 && odd_w)) begin
         f_w = $signed({1'b0, lo_w}) - 33'sh1_0000_0000;
      end else begin
         f_w = $signed({1'b0, lo_w});
      end
      x2_w = 32'((ff_ff + 64'h2_0000_0000) >> 34);
      vld_in = {vld_ff[NSTG-2:0], ctl.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         sum_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         if (ctl.start) begin
            sum_ff <= '0;
         end else if (vld_ff[NSTG-1]) begin
            sum_ff <= sum_ff + 64'(rep_ff[11] * c_ff[11])
                      - 64'(imp_ff[11] * s_ff[11]);
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff  <= 37'(ctl.n * x_val);
      py_ff  <= 37'(ctl.m * y_val);
      re1_ff <= c_re;
      im1_ff <= c_im;
      ph_ff  <= 38'(px_ff) + 38'(py_ff);
      re2_ff <= re1_ff;
      im2_ff <= im1_ff;
      // phase * INV: split phase into two 19-bit halves so each product fits 48 bits
      tl_ff  <= 48'($signed({1'b0, ph_ff[18:0]}) * INV_TWO_PI);
      th_ff  <= 48'($signed(ph_ff[37:19]) * INV_TWO_PI);
      re3_ff <= re2_ff;
      im3_ff <= im2_ff;
      f_ff   <= f_w;
      re4_ff <= re3_ff;
      im4_ff <= im3_ff;
      ff_ff  <= 64'(f_ff * f_ff);
      f5_ff  <= f_ff;
      re5_ff <= re4_ff;
      im5_ff <= im4_ff;
      // Horner step 1
      x2_ff[6]  <= x2_w;
      fp_ff[6]  <= f5_ff;
      rep_ff[6] <= re5_ff;
      imp_ff[6] <= im5_ff;
      c_ff[6]   <= COS_C6;
      s_ff[6]   <= SIN_S7;
      for (int i = 7; i <= 8; i++) begin
         x2_ff[i] <= x2_ff[i-1];
      end
      for (int i = 7; i <= 9; i++) begin
         fp_ff[i] <= fp_ff[i-1];
      end
      for (int i = 7; i <= 11; i++) begin
         rep_ff[i] <= rep_ff[i-1];
         imp_ff[i] <= imp_ff[i-1];
      end
      c_ff[7]  <= COS_C4 + rnd(64'(c_ff[6] * x2_ff[6]), 30);
      s_ff[7]  <= SIN_S5 + rnd(64'(s_ff[6] * x2_ff[6]), 30);
      c_ff[8]  <= COS_C2 + rnd(64'(c_ff[7] * x2_ff[7]), 30);
      s_ff[8]  <= SIN_S3 + rnd(64'(s_ff[7] * x2_ff[7]), 30);
      c_ff[9]  <= COS_C0 + rnd(64'(c_ff[8] * x2_ff[8]), 30);
      s_ff[9]  <= SIN_S1 + rnd(64'(s_ff[8] * x2_ff[8]), 30);
      c_ff[10] <= c_ff[9];
      s_ff[10] <= rnd(64'(s_ff[9] * fp_ff[9]), 32);
      c_ff[11] <= c_ff[10];
      s_ff[11] <= s_ff[10];
   end

   assign busy = |vld_ff;
   assign sum  = sum_ff;

endmodule
